// ----- src/spsg_pkg.sv -----
// spsg_pkg: types and constants for the servo pulse schedule generator
// no dependencies
package spsg_pkg;

	localparam int Channels = 12;
	localparam int FrameLen = 24;
	localparam logic signed [7:0] PosLimit = 8'sd100;
	localparam logic [15:0] LinkBit = 16'h0040;

	localparam logic [1:0] CfgStagger = 2'd0;
	localparam logic [1:0] CfgCentre = 2'd1;
	localparam logic [1:0] CfgGap = 2'd2;

	typedef struct packed {
		logic action;
		logic [7:0] channel;
		logic signed [15:0] position;
	} req_t;

	typedef struct packed {
		logic [15:0] pin_word;
		logic [15:0] duration;
		logic [4:0] command_index;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SORT,
		ST_EMIT,
		ST_OUT
	} state_t;

	// external channel to internal index
	function automatic logic [3:0] chan_map(input logic [3:0] ch);
		logic [3:0] r;
		begin
			case (ch)
				4'd0: r = 4'd11;
				4'd1: r = 4'd10;
				4'd2: r = 4'd9;
				4'd3: r = 4'd8;
				4'd4: r = 4'd7;
				4'd5: r = 4'd6;
				4'd6: r = 4'd5;
				4'd7: r = 4'd4;
				4'd8: r = 4'd0;
				4'd9: r = 4'd1;
				4'd10: r = 4'd2;
				4'd11: r = 4'd3;
				default: r = 4'd0;
			endcase
			return r;
		end
	endfunction

	function automatic logic [15:0] pin_bit(input logic [3:0] idx);
		logic [3:0] sh;
		begin
			sh = (idx < 4'd4) ? idx : idx + 4'd4;
			return 16'd1 << sh;
		end
	endfunction

	// clamp a signed 18 bit difference to 1..65535
	function automatic logic [15:0] sat_dur(input logic signed [17:0] d);
		begin
			if (d < 18'sd1) return 16'd1;
			if (d > 18'sd65535) return 16'hFFFF;
			return d[15:0];
		end
	endfunction

endpackage

// ----- src/spsg_sorter.sv -----
// spsg_sorter: insertion sort of channel indices by pulse length, one compare a cycle
// depends on spsg_pkg
module spsg_sorter (
	input logic clk,
	input logic arst_n,
	input logic go,
	input logic signed [13:0] len [spsg_pkg::Channels],
	output logic done,
	output logic [3:0] order [spsg_pkg::Channels]
);

	logic [3:0] i_q;
	logic [3:0] j_q;
	logic busy_q;
	logic signed [13:0] lv;
	logic signed [13:0] lp;
	logic shift;

	assign lv = len[i_q];
	assign lp = len[order[j_q - 4'd1]];
	assign shift = (j_q != 4'd0) && (lp > lv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			done <= 1'b0;
			for (int i = 0; i < spsg_pkg::Channels; i++) order[i] <= '0;
		end else begin
			done <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				i_q <= '0;
				j_q <= '0;
			end else if (busy_q) begin
				if (shift) begin
					order[j_q] <= order[j_q - 4'd1];
					j_q <= j_q - 4'd1;
				end else begin
					order[j_q] <= i_q;
					if (i_q == 4'(spsg_pkg::Channels - 1)) begin
						busy_q <= 1'b0;
						done <= 1'b1;
					end else begin
						i_q <= i_q + 4'd1;
						j_q <= i_q + 4'd1;
					end
				end
			end
		end
	end

endmodule

// ----- src/servo_pulse_schedule_generator.sv -----
// servo_pulse_schedule_generator: top level, request decode, schedule table and sequencer
// depends on spsg_pkg and spsg_sorter
// A set request is taken while busy is low and busy stays low, so the next request can follow at
// once. An advance raises busy in the cycle after it is taken, and its result passes through
// rd_q and out_q, then res_q and done_q, to the result ports with done high. The advance that
// emits command 23 also rebuilds the schedule: an insertion sort with one length compare per
// cycle (12 inserts plus up to 66 shifts), then writing the 24 entries of the command table,
// one entry a cycle, and busy stays high until that is done. After reset the same rebuild runs
// before the first request is taken. Results appear for one cycle with done high and cannot be
// held off by the receiver.
module servo_pulse_schedule_generator (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input spsg_pkg::req_t req,
	output logic done,
	output spsg_pkg::res_t res,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data
);

	localparam int Ch = spsg_pkg::Channels;

	logic [7:0] stagger_q;
	logic [11:0] centre_q;
	logic [15:0] gap_q;
	logic signed [7:0] pos_q [Ch];
	logic [31:0] table_q [spsg_pkg::FrameLen];
	logic [4:0] next_q;
	logic [4:0] cmd_q;
	logic [15:0] acc_q;
	logic [4:0] k_q;
	logic [31:0] rd_q;
	logic out_q;
	logic done_q;
	spsg_pkg::res_t res_q;
	spsg_pkg::state_t state_q, state_d;
	logic signed [13:0] len [Ch];
	logic [3:0] order [Ch];
	logic sort_go, sort_done;
	logic [3:0] ord_k, ord_n;
	logic signed [17:0] dur_d;
	logic [15:0] pins_d;
	logic [15:0] acc_d;
	logic signed [15:0] clamp;
	logic take_adv;

	assign take_adv = (state_q == spsg_pkg::ST_IDLE) && start && req.action;

	always_comb begin
		for (int i = 0; i < Ch; i++) len[i] = $signed({2'b0, centre_q}) + 14'(pos_q[i]);
	end

	spsg_sorter u_sort (
		.clk(clk), .arst_n(arst_n), .go(sort_go), .len(len), .done(sort_done), .order(order)
	);

	// command k of the rebuild
	always_comb begin
		logic [15:0] pb;
		logic signed [17:0] st;
		ord_k = (k_q < 5'd12) ? k_q[3:0] : 4'(k_q - 5'd12);
		ord_n = (ord_k == 4'd11) ? 4'd11 : ord_k + 4'd1;
		pb = spsg_pkg::pin_bit(order[ord_k]);
		st = 18'($signed({1'b0, stagger_q}));
		acc_d = (k_q < 5'd12) ? (acc_q | pb) : (acc_q & ~pb);
		pins_d = acc_d | spsg_pkg::LinkBit;
		if (k_q < 5'd11) dur_d = st;
		else if (k_q == 5'd11) dur_d = 18'(len[order[0]]) - st * 18'sd11;
		else if (k_q < 5'd23) dur_d = 18'(len[order[ord_n]]) - 18'(len[order[ord_k]]) + st;
		else dur_d = 18'($signed({2'b0, gap_q}));
	end

	assign clamp = req.position > 16'sd100 ? 16'sd100 :
		(req.position < -16'sd100 ? -16'sd100 : req.position);

	always_comb begin
		state_d = state_q;
		sort_go = 1'b0;
		case (state_q)
			spsg_pkg::ST_IDLE: begin
				if (start && req.action) state_d = spsg_pkg::ST_OUT;
			end
			spsg_pkg::ST_OUT: begin
				if (next_q == 5'd0) begin
					sort_go = 1'b1;
					state_d = spsg_pkg::ST_SORT;
				end else state_d = spsg_pkg::ST_IDLE;
			end
			spsg_pkg::ST_SORT: if (sort_done) state_d = spsg_pkg::ST_EMIT;
			spsg_pkg::ST_EMIT: if (k_q == 5'd23) state_d = spsg_pkg::ST_IDLE;
			default: state_d = spsg_pkg::ST_IDLE;
		endcase
	end

	assign busy = (state_q != spsg_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spsg_pkg::ST_OUT;
			next_q <= '0;
			cmd_q <= '0;
			acc_q <= '0;
			k_q <= '0;
			stagger_q <= 8'd15;
			centre_q <= 12'd300;
			gap_q <= 16'd3000;
			for (int i = 0; i < Ch; i++) pos_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					spsg_pkg::CfgStagger: stagger_q <= cfg_data[7:0];
					spsg_pkg::CfgCentre: centre_q <= cfg_data[11:0];
					spsg_pkg::CfgGap: gap_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == spsg_pkg::ST_IDLE && start) begin
				if (!req.action && req.channel < 8'(Ch))
					pos_q[spsg_pkg::chan_map(req.channel[3:0])] <= clamp[7:0];
				if (req.action) begin
					cmd_q <= next_q;
					next_q <= (next_q == 5'd23) ? 5'd0 : next_q + 5'd1;
				end
			end
			if (state_q == spsg_pkg::ST_SORT) k_q <= '0;
			if (state_q == spsg_pkg::ST_EMIT) begin
				acc_q <= acc_d;
				k_q <= (k_q == 5'd23) ? 5'd0 : k_q + 5'd1;
			end
		end
	end

	// command table: one write a cycle while rebuilding, one registered read per advance
	always_ff @(posedge clk) begin
		if (state_q == spsg_pkg::ST_EMIT) table_q[k_q] <= {pins_d, spsg_pkg::sat_dur(dur_d)};
		if (take_adv) rd_q <= table_q[next_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= 1'b0;
			done_q <= 1'b0;
			res_q <= '0;
		end else begin
			out_q <= take_adv;
			done_q <= out_q;
			if (out_q) res_q <= {rd_q, cmd_q};
		end
	end

	assign done = done_q;
	assign res = res_q;

endmodule

// ----- sim/tb_servo_pulse_schedule_generator.sv -----
// tb_servo_pulse_schedule_generator: self-checking testbench for the servo pulse schedule
// generator; predicts every command word and checks each result; depends on spsg_pkg
module tb_servo_pulse_schedule_generator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SettleCycles = 150;
	localparam int StallLimit = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	spsg_pkg::req_t req = '0;
	logic done;
	spsg_pkg::res_t res;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = spsg_pkg::CfgStagger;
	logic [15:0] cfg_data = '0;

	servo_pulse_schedule_generator DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .res(res), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// schedule model state
	const int slot_of_channel[spsg_pkg::Channels] = '{11, 10, 9, 8, 7, 6, 5, 4, 0, 1, 2, 3};
	logic [7:0] stagger_q;
	logic [11:0] centre_q;
	logic [15:0] gap_q;
	int slot_pos[spsg_pkg::Channels];
	logic [15:0] sched_pins[spsg_pkg::FrameLen];
	logic [15:0] sched_dur[spsg_pkg::FrameLen];
	int sched_next;
	logic [15:0] pin_image;
	int pulse_order[spsg_pkg::Channels];
	spsg_pkg::res_t pending_cmds[$];
	int errors = 0;
	int n_requests = 0;
	int n_results = 0;
	int stall_count = 0;

	function automatic logic [15:0] clamp_ticks(input int d);
		if (d < 1) return 16'd1;
		if (d > 65535) return 16'hFFFF;
		return d[15:0];
	endfunction

	function automatic logic [15:0] set_pin(input logic high, input int slot);
		logic [15:0] b;
		b = 16'd1 << ((slot < 4) ? slot : slot + 4);
		pin_image = high ? (pin_image | b) : (pin_image & ~b);
		return pin_image | spsg_pkg::LinkBit;
	endfunction

	function automatic void build_schedule();
		int plen[spsg_pkg::Channels];
		int st;
		int j;
		int v;
		st = stagger_q;
		for (int i = 0; i < spsg_pkg::Channels; i++) plen[i] = int'(centre_q) + slot_pos[i];
		// stable insertion sort, ties keep lower slot first
		for (int i = 0; i < spsg_pkg::Channels; i++) begin
			v = i;
			j = i;
			while (j > 0 && plen[pulse_order[j-1]] > plen[v]) begin
				pulse_order[j] = pulse_order[j-1];
				j--;
			end
			pulse_order[j] = v;
		end
		for (int i = 0; i < spsg_pkg::Channels; i++) begin
			sched_pins[i] = set_pin(1'b1, pulse_order[i]);
			sched_dur[i] = (i < spsg_pkg::Channels - 1) ? clamp_ticks(st)
				: clamp_ticks(plen[pulse_order[0]] - st * (spsg_pkg::Channels - 1));
		end
		for (int i = 0; i < spsg_pkg::Channels; i++) begin
			sched_pins[spsg_pkg::Channels+i] = set_pin(1'b0, pulse_order[i]);
			sched_dur[spsg_pkg::Channels+i] = (i < spsg_pkg::Channels - 1)
				? clamp_ticks(plen[pulse_order[i+1]] - plen[pulse_order[i]] + st)
				: clamp_ticks(int'(gap_q));
		end
	endfunction

	function automatic void model_reset();
		stagger_q = 8'd15;
		centre_q = 12'd300;
		gap_q = 16'd3000;
		foreach (slot_pos[i]) slot_pos[i] = 0;
		foreach (pulse_order[i]) pulse_order[i] = 0;
		sched_next = 0;
		pin_image = '0;
		build_schedule();
	endfunction

	function automatic void model_request(input spsg_pkg::req_t r);
		int p;
		spsg_pkg::res_t c;
		if (r.action == 1'b0) begin
			if (r.channel < spsg_pkg::Channels) begin
				p = r.position;
				if (p > 100) p = 100;
				if (p < -100) p = -100;
				slot_pos[slot_of_channel[r.channel]] = p;
			end
		end else begin
			c.pin_word = sched_pins[sched_next];
			c.duration = sched_dur[sched_next];
			c.command_index = sched_next[4:0];
			pending_cmds.push_back(c);
			sched_next++;
			if (sched_next >= spsg_pkg::FrameLen) begin
				sched_next = 0;
				build_schedule();
			end
		end
	endfunction

	// result check, request capture and stall watchdog
	always @(posedge clk) begin
		spsg_pkg::res_t e;
		if (arst_n) begin
			if (done) begin
				n_results++;
				if (pending_cmds.size() == 0) begin
					$error("unexpected result pin_word=%h", res.pin_word);
					errors++;
				end else begin
					e = pending_cmds.pop_front();
					if (res.pin_word !== e.pin_word) begin
						$error("pin_word exp %h got %h", e.pin_word, res.pin_word);
						errors++;
					end
					if (res.duration !== e.duration) begin
						$error("duration exp %0d got %0d", e.duration, res.duration);
						errors++;
					end
					if (res.command_index !== e.command_index) begin
						$error("command_index exp %0d got %0d", e.command_index,
							res.command_index);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				n_requests++;
				model_request(req);
			end
			if (done || (start && !busy)) stall_count <= 0;
			else stall_count <= stall_count + 1;
			if (stall_count >= StallLimit) begin
				$display("watchdog: no progress for %0d cycles", StallLimit);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// call at a rising edge; returns at the edge that accepts the request
	task automatic send_request(input spsg_pkg::req_t r);
		logic taken;
		start <= 1'b1;
		req <= r;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic pause(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic set_pos(input logic [7:0] ch, input logic [15:0] p);
		spsg_pkg::req_t r;
		r.action = 1'b0;
		r.channel = ch;
		r.position = p;
		send_request(r);
	endtask

	task automatic advance();
		spsg_pkg::req_t r;
		r.action = 1'b1;
		r.channel = 8'($urandom);
		r.position = 16'($urandom);
		send_request(r);
	endtask

	// let the block drain, including a rebuild that yields no result
	task automatic wait_idle();
		start <= 1'b0;
		while (pending_cmds.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [1:0] idx, input logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			spsg_pkg::CfgStagger: stagger_q = v[7:0];
			spsg_pkg::CfgCentre: centre_q = v[11:0];
			spsg_pkg::CfgGap: gap_q = v;
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [15:0] st, input logic [15:0] ce,
			input logic [15:0] gp);
		wait_idle();
		write_cfg(spsg_pkg::CfgStagger, st);
		write_cfg(spsg_pkg::CfgCentre, ce);
		write_cfg(spsg_pkg::CfgGap, gp);
	endtask

	function automatic logic [15:0] rand_position();
		case ($urandom_range(0, 3))
			0, 1: return 16'($urandom_range(0, 220) - 110);
			2: return $urandom_range(0, 1) ? 16'd100 : -16'sd101;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_request(input bit allow_idle);
		int pick;
		if (allow_idle && $urandom_range(0, 3) == 0) pause($urandom_range(1, 9));
		pick = $urandom_range(0, 99);
		if (pick < 60) advance();
		else if (pick < 95)
			set_pos(8'($urandom_range(0, spsg_pkg::Channels - 1)), rand_position());
		else set_pos(8'($urandom), 16'($urandom));
	endtask

	// clamp limits, ignored channels, then a full frame and its rebuild
	task automatic test_directed();
		set_pos(8'd0, 16'h7FFF);
		set_pos(8'd11, 16'h8000);
		set_pos(8'd12, 16'd50);
		set_pos(8'd255, 16'h7FFF);
		set_pos(8'd3, 16'd101);
		set_pos(8'd4, -16'sd101);
		set_pos(8'd7, 16'd100);
		set_pos(8'd8, -16'sd100);
		set_pos(8'd5, 16'd100); // tie with channel 7
		repeat (spsg_pkg::FrameLen + 2) advance();
	endtask

	// register extremes, including zero values and a centre below range
	task automatic test_config_extremes();
		apply_settings(16'd255, 16'd4095, 16'hFFFF);
		repeat (2 * spsg_pkg::FrameLen) advance();
		apply_settings(16'd1, 16'd101, 16'd1);
		repeat (2 * spsg_pkg::FrameLen) advance();
		apply_settings(16'd0, 16'd0, 16'd0);
		for (int c = 0; c < spsg_pkg::Channels; c++) set_pos(8'(c), rand_position());
		repeat (2 * spsg_pkg::FrameLen) advance();
		apply_settings(16'd255, 16'd50, 16'd3000);
		repeat (2 * spsg_pkg::FrameLen) advance();
	endtask

	task automatic test_random();
		for (int n = 0; n < 1060; n++) begin
			if (n % 300 == 299)
				apply_settings(16'($urandom_range(1, 255)), 16'($urandom_range(101, 4095)),
					16'($urandom_range(1, 65535)));
			random_request(n < 880);
		end
		start <= 1'b0;
	endtask

	initial begin
		model_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_extremes();
		test_random();
		wait_idle();
		$display("covered %0d requests and %0d schedule commands over several settings",
			n_requests, n_results);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
